>>> sv/csq_pkg.sv
// Shared constants, types and helpers for the counting semaphore wait queue.
`timescale 1ns / 1ps

package csq_pkg;

   // Wait queue geometry
   localparam int QUEUE_DEPTH    = 16;
   localparam int THREAD_ID_BITS = 8;
   localparam int PTR_W          = $clog2(QUEUE_DEPTH);
   localparam int OCC_W          = $clog2(QUEUE_DEPTH + 1);

   // Field widths of the request and response channels
   localparam int REQ_TYPE_W = 2;
   localparam int TID_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 16;
   localparam int VALUE_W    = 17;

   localparam logic [TID_W-1:0]   ID_MASK   = TID_W'((1 << THREAD_ID_BITS) - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request opcodes; the unused code behaves as a read
   localparam logic [REQ_TYPE_W-1:0] REQ_DOWN = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_UP   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BLOCKED   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_SATURATED = 2'd3;

   // Control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } csq_state_type;

   // Circular pointer advance, valid for any depth
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

endpackage

>>> sv/csq_ifs.sv
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface csq_req_if;
   import csq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [TID_W-1:0]      thread_id;
   modport source (output valid, output req_type, output thread_id, input ready);
   modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface

interface csq_rsp_if;
   import csq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic                       woken_valid;
   logic [TID_W-1:0]           woken_thread;
   logic signed [VALUE_W-1:0]  current_value;
   modport source (output valid, output status, output woken_valid, output woken_thread,
                   output current_value, input ready);
   modport sink   (input valid, input status, input woken_valid, input woken_thread,
                   input current_value, output ready);
endinterface

interface csq_csr_if;
   import csq_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/csq_id_ram.sv
// Simple dual-port RAM with registered read, holds the waiting thread ids.
`timescale 1ns / 1ps

module csq_id_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/counting_semaphore_wait_queue.sv
// Top level: counting semaphore with a FIFO wait queue of blocked thread ids.
`timescale 1ns / 1ps
//
// Usage:
//   req (csq_req_if): down, up or read requests with the caller's thread id.
//   rsp (csq_rsp_if): one response per request: status, woken waiter, value.
//   csr (csq_csr_if): write of initial_count; reloads the count and empties
//                     the wait queue. Taken only while no request is in work.
// Timing: a response is registered in the cycle after its request is taken.
//   An up request that hands the unit to a waiter reads the id RAM, and its
//   response is registered from the RAM output in the fetch state.
// Throughput: one request per cycle unless a csr write or a held response blocks it;
//   none is taken in the fetch state of a handoff (single registered id RAM read port).
// Reset: count and initial_count clear to zero, the wait queue is empty.
//   No clearing pass: the id RAM is only read at written entries.
// Stall: the response register holds while rsp.ready is low; a new request is
//   taken in the same cycle the held response leaves.
//
module counting_semaphore_wait_queue (
   input logic      clock,
   input logic      reset,
   csq_req_if.sink  req,
   csq_rsp_if.source rsp,
   csq_csr_if.sink  csr
);

   import csq_pkg::*;

   csq_state_type state_ff, state_in;

   logic [COUNT_W-1:0] init_ff, init_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                woken_valid_ff, woken_valid_in;
   logic [TID_W-1:0]    woken_ff;
   logic [VALUE_W-1:0]  value_ff, value_in;

   logic             req_fire;
   logic             csr_fire;
   logic             handoff;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [TID_W-1:0] ram_rd_data;
   logic             rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req_fire = req.valid && req.ready;
   assign csr_fire = csr.valid && csr.ready;

   // Id storage
   csq_id_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (TID_W)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req.thread_id & ID_MASK),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (handoff) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req.ready = 1'b0;
      csr.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            csr.ready = 1'b1;
            req.ready = rsp_free && !csr.valid;
         end
         ST_FETCH: begin
            req.ready = 1'b0;
            csr.ready = 1'b0;
         end
         default: begin
            req.ready = 1'b0;
            csr.ready = 1'b0;
         end
      endcase
   end

   // Read-modify-write of the semaphore state
   always_comb begin
      init_in        = init_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      status_in      = STAT_OK;
      woken_valid_in = 1'b0;
      handoff        = 1'b0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      if (csr_fire) begin
         init_in  = csr.data;
         count_in = csr.data;
         head_in  = '0;
         tail_in  = '0;
         occ_in   = '0;
      end else if (req_fire) begin
         unique case (req.req_type)
            REQ_DOWN: begin
               priority if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end else if (occ_ff != OCC_W'(QUEUE_DEPTH)) begin
                  ram_wr_en = 1'b1;
                  tail_in   = next_ptr(tail_ff);
                  occ_in    = occ_ff + OCC_W'(1);
                  status_in = STAT_BLOCKED;
               end else begin
                  status_in = STAT_FULL;
               end
            end
            REQ_UP: begin
               priority if (occ_ff != '0) begin
                  handoff        = 1'b1;
                  ram_rd_en      = 1'b1;
                  head_in        = next_ptr(head_ff);
                  occ_in         = occ_ff - OCC_W'(1);
                  woken_valid_in = 1'b1;
               end else if (count_ff == COUNT_MAX) begin
                  status_in = STAT_SATURATED;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            default: begin
               // read: no state change
            end
         endcase
      end
      // value after the request: count, else minus the waiters
      if (count_in != '0) begin
         value_in = VALUE_W'(count_in);
      end else begin
         value_in = VALUE_W'(0) - VALUE_W'(occ_in);
      end
   end

   // Response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (state_ff == ST_FETCH) begin
         rsp_valid_in = 1'b1;
      end else if (req_fire) begin
         rsp_valid_in = !handoff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_ff      <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff      <= status_in;
         woken_valid_ff <= woken_valid_in;
         woken_ff       <= '0;
         value_ff       <= value_in;
      end else if (state_ff == ST_FETCH) begin
         woken_ff <= ram_rd_data;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.woken_valid   = woken_valid_ff;
   assign rsp.woken_thread  = woken_ff;
   assign rsp.current_value = signed'(value_ff);

`ifndef NO_ASSERTIONS
   // waiters never exceed the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("wait queue occupancy beyond depth");

   // a positive count and queued waiters never coexist
   a_count_or_wait: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (occ_ff == '0))
      else $error("count above zero with threads waiting");

   // a handoff request enters the fetch state with no response valid
   a_fetch_origin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_fire && handoff) |=> (state_ff == ST_FETCH && !rsp_valid_ff))
      else $error("handoff did not enter fetch");

   // a woken waiter is always reported with ok status
   a_woken_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.woken_valid) |-> (rsp.status == STAT_OK))
      else $error("woken waiter with non-ok status");
`endif

endmodule

>>> verif/counting_semaphore_wait_queue_tb.sv
// Self-checking testbench for the counting semaphore wait queue: directed table then random traffic.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue_tb;
   import csq_pkg::*;

   // Unused opcode, decoded by the block as a read
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE = 2'd3;

   localparam int RUN_LIMIT       = 200000;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASE_COUNT     = 8;
   localparam int PHASE_REQUESTS  = 124;
   localparam int SQUEEZE_COUNT   = 60;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TABLE_ROWS      = 15;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      woken_valid;
      logic [TID_W-1:0]          woken_thread;
      logic signed [VALUE_W-1:0] current_value;
   } sem_rsp_type;

   // Response typed into the directed table, or left to the predictor
   typedef struct packed {
      logic        fixed;
      sem_rsp_type rsp;
   } table_rsp_type;

   typedef struct {
      logic                      is_cfg;
      logic [COUNT_W-1:0]        cfg_value;
      logic [REQ_TYPE_W-1:0]     rtype;
      logic [TID_W-1:0]          tid;
      int                        copies;
      logic                      fixed;
      logic [STATUS_W-1:0]       exp_status;
      logic                      exp_woken;
      logic [TID_W-1:0]          exp_tid;
      logic signed [VALUE_W-1:0] exp_value;
   } stim_row_type;

   logic          clock;
   logic          reset;
   idle_mode_type idle_mode;
   logic          hold_off_go;
   int            fail_count = 0;
   int            cycle_count = 0;

   // Predictor state
   logic [COUNT_W-1:0] model_initial;
   logic [COUNT_W-1:0] model_count;
   logic [TID_W-1:0]   model_ids [QUEUE_DEPTH];
   logic [PTR_W-1:0]   model_head;
   logic [PTR_W-1:0]   model_tail;
   logic [OCC_W-1:0]   model_occ;

   sem_rsp_type   pending_results [$];
   table_rsp_type table_results [$];
   stim_row_type  directed_table [TABLE_ROWS];

   csq_req_if req ();
   csq_rsp_if rsp ();
   csq_csr_if csr ();

   counting_semaphore_wait_queue dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Reload the semaphore: new count, empty wait queue
   function automatic void semaphore_load(input logic [COUNT_W-1:0] value);
      model_initial = value;
      model_count   = value;
      model_head    = '0;
      model_tail    = '0;
      model_occ     = '0;
   endfunction

   // Apply one request to the predictor and return the response it owes
   function automatic sem_rsp_type semaphore_apply(input logic [REQ_TYPE_W-1:0] rtype,
                                                   input logic [TID_W-1:0] tid);
      sem_rsp_type r;
      r = '0;
      r.status = STAT_OK;
      if (rtype == REQ_DOWN) begin
         if (model_count != '0) begin
            model_count = model_count - COUNT_W'(1);
         end else if (int'(model_occ) < QUEUE_DEPTH) begin
            model_ids[model_tail] = tid & ID_MASK;
            model_tail = PTR_W'((int'(model_tail) + 1) % QUEUE_DEPTH);
            model_occ  = model_occ + OCC_W'(1);
            r.status   = STAT_BLOCKED;
         end else begin
            r.status = STAT_FULL;
         end
      end else if (rtype == REQ_UP) begin
         // handoff to the oldest waiter keeps the count as it is
         if (model_occ != '0) begin
            r.woken_valid  = 1'b1;
            r.woken_thread = model_ids[model_head];
            model_head = PTR_W'((int'(model_head) + 1) % QUEUE_DEPTH);
            model_occ  = model_occ - OCC_W'(1);
         end else if (model_count == COUNT_MAX) begin
            r.status = STAT_SATURATED;
         end else begin
            model_count = model_count + COUNT_W'(1);
         end
      end
      if (model_count != '0) begin
         r.current_value = VALUE_W'(model_count);
      end else begin
         r.current_value = VALUE_W'(-int'(model_occ));
      end
      return r;
   endfunction

   task automatic note_failure(input string what);
      if (fail_count < MAX_REPORTS) begin
         $display("%0t: %s", $realtime, what);
      end
      fail_count++;
   endtask

   // Score responses, track register writes, predict accepted requests
   always @(posedge clock) begin : scoreboard
      sem_rsp_type   got;
      sem_rsp_type   want;
      table_rsp_type row;
      if (reset) begin
         semaphore_load('0);
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.status        = rsp.status;
            got.woken_valid   = rsp.woken_valid;
            got.woken_thread  = rsp.woken_thread;
            got.current_value = rsp.current_value;
            if (pending_results.size() == 0) begin
               note_failure("response with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  note_failure($sformatf({"mismatch: status %0d/%0d woken %0b/%0b ",
                     "id %h/%h value %0d/%0d (expected/actual)"},
                     want.status, got.status, want.woken_valid, got.woken_valid,
                     want.woken_thread, got.woken_thread,
                     want.current_value, got.current_value));
               end
            end
         end
         if (csr.valid && csr.ready) begin
            semaphore_load(csr.data);
         end
         if (req.valid && req.ready) begin
            want = semaphore_apply(req.req_type, req.thread_id);
            row = table_results.pop_front();
            if (row.fixed) begin
               want = row.rsp;
            end
            pending_results.push_back(want);
         end
      end
   end

   // Receiver: random stalls per idle mode, plus one long hold-off
   initial begin : receiver
      int   stall_left;
      logic hold_done;
      int   stall_pct;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_OFF_CYCLES;
         end
         stall_pct = (idle_mode == IDLE_RECEIVER) ? 48 : (idle_mode == IDLE_BOTH) ? 17 : 0;
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("counting_semaphore_wait_queue_tb NOT OK");
         $finish;
      end
   end

   // Offer one request, with random gaps first, and hold it until taken
   task automatic send_request(input logic [REQ_TYPE_W-1:0] rtype,
                               input logic [TID_W-1:0] tid,
                               input logic fixed,
                               input sem_rsp_type typed_rsp);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 48 : (idle_mode == IDLE_BOTH) ? 17 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      table_results.push_back('{fixed, typed_rsp});
      req.valid     <= 1'b1;
      req.req_type  <= rtype;
      req.thread_id <= tid;
      do @(posedge clock); while (!req.ready);
   endtask

   // Stop offering, wait until every response is back, then let the pipeline settle
   task automatic wait_until_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || table_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_initial_count(input logic [COUNT_W-1:0] value);
      csr.valid <= 1'b1;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   initial begin : stimulus
      sem_rsp_type           typed_rsp;
      logic [REQ_TYPE_W-1:0] rtype;
      logic [COUNT_W-1:0]    start_count;
      int                    run_left;
      logic                  run_up;

      req.valid     = 1'b0;
      req.req_type  = REQ_READ;
      req.thread_id = '0;
      csr.valid     = 1'b0;
      csr.data      = '0;
      reset         = 1'b1;
      idle_mode     = IDLE_NONE;
      hold_off_go   = 1'b0;
      run_left      = 0;
      run_up        = 1'b0;

      // Directed: empty semaphore, handoff, saturation, queue full
      directed_table = '{
         '{1'b0, 16'h0000, REQ_READ,  8'h00, 1,  1'b1, STAT_OK,        1'b0, 8'h00,   17'sd0},
         '{1'b0, 16'h0000, REQ_DOWN,  8'hFF, 1,  1'b1, STAT_BLOCKED,   1'b0, 8'h00,  -17'sd1},
         '{1'b0, 16'h0000, REQ_UP,    8'h00, 1,  1'b1, STAT_OK,        1'b1, 8'hFF,   17'sd0},
         '{1'b0, 16'h0000, REQ_UP,    8'h00, 1,  1'b1, STAT_OK,        1'b0, 8'h00,   17'sd1},
         '{1'b0, 16'h0000, REQ_SPARE, 8'h5A, 1,  1'b1, STAT_OK,        1'b0, 8'h00,   17'sd1},
         '{1'b0, 16'h0000, REQ_DOWN,  8'hA5, 1,  1'b1, STAT_OK,        1'b0, 8'h00,   17'sd0},
         '{1'b1, 16'hFFFF, REQ_READ,  8'h00, 0,  1'b0, STAT_OK,        1'b0, 8'h00,   17'sd0},
         '{1'b0, 16'h0000, REQ_UP,    8'h00, 1,  1'b1, STAT_SATURATED, 1'b0, 8'h00,   17'sd65535},
         '{1'b0, 16'h0000, REQ_DOWN,  8'h3C, 1,  1'b1, STAT_OK,        1'b0, 8'h00,   17'sd65534},
         '{1'b0, 16'h0000, REQ_UP,    8'h00, 1,  1'b1, STAT_OK,        1'b0, 8'h00,   17'sd65535},
         '{1'b1, 16'h0000, REQ_READ,  8'h00, 0,  1'b0, STAT_OK,        1'b0, 8'h00,   17'sd0},
         '{1'b0, 16'h0000, REQ_DOWN,  8'hF0, 16, 1'b0, STAT_OK,        1'b0, 8'h00,   17'sd0},
         '{1'b0, 16'h0000, REQ_DOWN,  8'h0F, 1,  1'b1, STAT_FULL,      1'b0, 8'h00,  -17'sd16},
         '{1'b0, 16'h0000, REQ_UP,    8'h00, 1,  1'b1, STAT_OK,        1'b1, 8'hF0,  -17'sd15},
         '{1'b0, 16'h0000, REQ_READ,  8'h00, 1,  1'b1, STAT_OK,        1'b0, 8'h00,  -17'sd15}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i]) begin
         if (directed_table[i].is_cfg) begin
            wait_until_drained();
            write_initial_count(directed_table[i].cfg_value);
         end else begin
            for (int k = 0; k < directed_table[i].copies; k++) begin
               typed_rsp.status        = directed_table[i].exp_status;
               typed_rsp.woken_valid   = directed_table[i].exp_woken;
               typed_rsp.woken_thread  = directed_table[i].exp_tid;
               typed_rsp.current_value = directed_table[i].exp_value;
               send_request(directed_table[i].rtype, directed_table[i].tid + TID_W'(k),
                            directed_table[i].fixed, typed_rsp);
            end
         end
      end

      // Random phases: a fresh starting count each, idle modes in rotation
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_until_drained();
         idle_mode = idle_mode_type'(phase % 4);
         case (phase)
            0, 5:    start_count = '0;
            1:       start_count = COUNT_MAX;
            2:       start_count = COUNT_W'($urandom_range(1, 6));
            3:       start_count = COUNT_MAX - COUNT_W'($urandom_range(0, 6));
            4:       start_count = COUNT_W'($urandom_range(0, 65535));
            6:       start_count = COUNT_W'($urandom_range(0, 3));
            default: start_count = COUNT_MAX - COUNT_W'($urandom_range(0, 20));
         endcase
         write_initial_count(start_count);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // runs of mostly downs or mostly ups fill and drain the queue and count
            if (run_left == 0) begin
               run_left = $urandom_range(1, 24);
               run_up   = ($urandom_range(0, 1) != 0);
            end
            run_left--;
            if ($urandom_range(0, 99) < 80) begin
               rtype = run_up ? REQ_UP : REQ_DOWN;
            end else begin
               case ($urandom_range(0, 3))
                  0:       rtype = REQ_DOWN;
                  1:       rtype = REQ_UP;
                  2:       rtype = REQ_READ;
                  default: rtype = REQ_SPARE;
               endcase
            end
            send_request(rtype, TID_W'($urandom_range(0, 255)), 1'b0, '0);
         end
      end

      // Back-pressure: receiver holds off while the sender keeps offering
      wait_until_drained();
      idle_mode   = IDLE_NONE;
      hold_off_go = 1'b1;
      for (int n = 0; n < SQUEEZE_COUNT; n++) begin
         rtype = ($urandom_range(0, 1) != 0) ? REQ_UP : REQ_DOWN;
         send_request(rtype, TID_W'($urandom_range(0, 255)), 1'b0, '0);
      end

      wait_until_drained();
      if (pending_results.size() != 0) begin
         note_failure("responses still outstanding at end of run");
      end
      if (fail_count == 0) begin
         $display("counting_semaphore_wait_queue_tb OK");
      end else begin
         $display("counting_semaphore_wait_queue_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/csq_pkg.sv
sv/csq_ifs.sv
sv/csq_id_ram.sv
sv/counting_semaphore_wait_queue.sv
verif/counting_semaphore_wait_queue_tb.sv
